FILE: rtl/core/cct_pkg.sv
// cct_pkg: shared types and constants of the contact count table
// table size, counter width, item kinds and the shared unit's operation codes
// no dependencies
package cct_pkg;

  // table geometry
  localparam int NUM_ENTRIES = 64;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int COUNT_W     = 24;
  localparam int HIGH_W      = 16;
  localparam int HIGH_LSB    = 8;

  // item field widths
  localparam int KIND_W   = 2;
  localparam int ID_W     = 8;
  localparam int AMOUNT_W = 16;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_HEARD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SNAPSHOT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ     = 2'd3;

  // shared adder operation
  typedef logic alu_op_t;
  localparam alu_op_t ALU_ADD = 1'b0;
  localparam alu_op_t ALU_SUB = 1'b1;

  typedef logic [COUNT_W-1:0] count_t;

endpackage

FILE: rtl/core/cct_alu.sv
// cct_alu: shared 24-bit add / subtract unit, wrapping modulo 2^24
// used for heard additions, acknowledge subtractions and snapshot copies
// depends on cct_pkg
module cct_alu (
  input  cct_pkg::alu_op_t op,
  input  cct_pkg::count_t  a,
  input  cct_pkg::count_t  b,
  output cct_pkg::count_t  y
);
  import cct_pkg::*;

  // wrapping add or subtract
  always_comb begin
    unique case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      default: y = a;
    endcase
  end

endmodule

FILE: rtl/core/contact_count_table_core.sv
// contact_count_table_core: two tables of per-neighbour 24-bit contact counters
// holds both table memories, the entry sequencer and the output register
// depends on cct_pkg and cct_alu
//
// Usage
//   Items arrive on item_valid / item_ready with fields kind, entry_id and
//   amount. Each item gives exactly one result on result_valid / result_ready
//   with fields count_high and status.
//   heard (kind 0) adds amount to current[entry_id]; id zero or an id at or
//   above the table size is ignored with status 1. read (kind 3) returns
//   bits 23..8 of sent[entry_id]; status 1 when the id is out of range.
//   snapshot (kind 1) copies current into sent; acknowledge (kind 2)
//   subtracts sent from current entry by entry and clears sent.
// Sequencing
//   heard and read: one registered table read, then the EXEC state, which
//   writes the sum through the shared adder (heard, unless ignored) or
//   captures the count (read); the result is then held in the DONE state.
//   snapshot and acknowledge: the sequencer walks every entry with a read
//   state (SWRD) and then a write state (SWWR) per entry, and presents the
//   result in the DONE state.
//   item_ready is high only while no item is in work and no result waits.
// Reset
//   rst clears the sequencer and the per-entry valid bits, so both tables
//   read as zero at once; no clearing pass is needed. item_ready is low
//   while rst is high.
// Stall
//   a result holds its fields until result_ready; no new item is taken
//   meanwhile.
module contact_count_table_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [cct_pkg::KIND_W-1:0]    kind,
  input  logic [cct_pkg::ID_W-1:0]      entry_id,
  input  logic [cct_pkg::AMOUNT_W-1:0]  amount,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [cct_pkg::HIGH_W-1:0]    count_high,
  output logic                          status
);
  import cct_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_SWRD = 3'd2;
  localparam logic [2:0] ST_SWWR = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [KIND_W-1:0]   kind_q;
  logic [AMOUNT_W-1:0] amount_q;
  logic [IDX_W-1:0]    idx;
  logic                ign_q;

  // table memories and their per-entry valid bits
  count_t                 cur_mem  [NUM_ENTRIES];
  count_t                 sent_mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] cur_vld;
  logic [NUM_ENTRIES-1:0] sent_vld;

  count_t cur_q;
  count_t sent_q;
  logic   cur_vq;
  logic   sent_vq;
  count_t cur_val;
  count_t sent_val;

  logic             accept;
  logic [IDX_W-1:0] item_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             in_range;
  logic             ign;
  logic             is_sweep;
  logic             last_idx;

  logic    cur_we;
  logic    sent_we;
  logic    sent_clr;
  alu_op_t alu_op;
  count_t  alu_b;
  count_t  alu_y;

  assign item_ready   = (state == ST_IDLE) && !rst;
  assign result_valid = (state == ST_DONE);
  assign accept       = item_valid && item_ready;

  // item decode
  assign item_idx = entry_id[IDX_W-1:0];
  assign in_range = ({1'b0, entry_id} < 9'(NUM_ENTRIES));
  assign is_sweep = (kind == KIND_SNAPSHOT) || (kind == KIND_ACK);
  assign ign      = ((kind == KIND_HEARD) && ((entry_id == '0) || !in_range))
                 || ((kind == KIND_READ) && !in_range);
  assign last_idx = (idx == IDX_W'(NUM_ENTRIES - 1));

  // read address: the incoming id while idle, else the working index
  assign rd_idx = (state == ST_IDLE) ? item_idx : idx;

  // registered table reads
  always_ff @(posedge clk) begin
    cur_q   <= cur_mem[rd_idx];
    sent_q  <= sent_mem[rd_idx];
    cur_vq  <= cur_vld[rd_idx];
    sent_vq <= sent_vld[rd_idx];
  end

  assign cur_val  = cur_vq  ? cur_q  : '0;
  assign sent_val = sent_vq ? sent_q : '0;

  // shared adder operands
  always_comb begin
    alu_op = ALU_ADD;
    alu_b  = '0;
    unique case (kind_q)
      KIND_HEARD: alu_b = {{(COUNT_W-AMOUNT_W){1'b0}}, amount_q};
      KIND_ACK: begin
        alu_op = ALU_SUB;
        alu_b  = sent_val;
      end
      default: alu_b = '0;
    endcase
  end

  cct_alu u_alu (
    .op (alu_op),
    .a  (cur_val),
    .b  (alu_b),
    .y  (alu_y)
  );

  // write enables
  assign cur_we   = ((state == ST_EXEC) && (kind_q == KIND_HEARD) && !ign_q)
                 || ((state == ST_SWWR) && (kind_q == KIND_ACK));
  assign sent_we  = (state == ST_SWWR) && (kind_q == KIND_SNAPSHOT);
  assign sent_clr = (state == ST_SWWR) && (kind_q == KIND_ACK);

  // table writes
  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[idx] <= alu_y;
    end
    if (sent_we) begin
      sent_mem[idx] <= alu_y;
    end
  end

  // valid bits: reset makes every entry read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vld  <= '0;
      sent_vld <= '0;
    end else begin
      if (cur_we) begin
        cur_vld[idx] <= 1'b1;
      end
      if (sent_we) begin
        sent_vld[idx] <= 1'b1;
      end else if (sent_clr) begin
        sent_vld[idx] <= 1'b0;
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = is_sweep ? ST_SWRD : ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_DONE;
      ST_SWRD: state_next = ST_SWWR;
      ST_SWWR: state_next = last_idx ? ST_DONE : ST_SWRD;
      ST_DONE: begin
        if (result_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture and working index
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q   <= kind;
      amount_q <= amount;
      ign_q    <= ign;
      idx      <= is_sweep ? '0 : item_idx;
    end else if ((state == ST_SWWR) && !last_idx) begin
      idx <= idx + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      count_high <= '0;
      status     <= ign;
    end else if ((state == ST_EXEC) && (kind_q == KIND_READ) && !ign_q) begin
      count_high <= sent_val[HIGH_LSB +: HIGH_W];
    end
  end

endmodule

FILE: rtl/core/cct_checker.sv
// cct_checker: port-level checks on the contact count table
// bound to contact_count_table_core; depends on cct_pkg
module cct_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic [cct_pkg::KIND_W-1:0]    kind,
  input logic [cct_pkg::ID_W-1:0]      entry_id,
  input logic [cct_pkg::AMOUNT_W-1:0]  amount,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic [cct_pkg::HIGH_W-1:0]    count_high,
  input logic                          status
);
  import cct_pkg::*;

  // a stalled result holds its fields
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(count_high)
      && $stable(status))
    else $error("result changed while stalled");

  // an ignored item never carries a count
  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status |-> count_high == '0)
    else $error("ignored item returned a count");

  // one item at a time: no intake while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid))
    else $error("item taken while a result waits");

  // an accepted item occupies the block the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready && !result_valid)
    else $error("block free right after accepting an item");

endmodule

bind contact_count_table_core cct_checker u_cct_checker (.*);

FILE: bench/contact_count_checker.sv
`timescale 1ns / 100ps
// contact_count_checker: shadow copies of the current and sent counter tables
// predicts the result of every accepted item and compares it with the core's output
// depends on cct_pkg
module contact_count_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_ready,
  input  logic [cct_pkg::KIND_W-1:0]    kind,
  input  logic [cct_pkg::ID_W-1:0]      entry_id,
  input  logic [cct_pkg::AMOUNT_W-1:0]  amount,
  input  logic                          result_valid,
  input  logic                          result_ready,
  input  logic [cct_pkg::HIGH_W-1:0]    count_high,
  input  logic                          status,
  output int                            mismatch_count,
  output int                            awaited_count
);
  import cct_pkg::*;

  typedef struct packed {
    logic [HIGH_W-1:0] count_high;
    logic              status;
  } contact_result_t;

  count_t          shadow_current [NUM_ENTRIES];
  count_t          shadow_sent    [NUM_ENTRIES];
  contact_result_t awaited_results [$];
  int              error_total = 0;

  // apply one item to the shadow tables and return the result it should give
  function automatic contact_result_t apply_contact_item(input logic [KIND_W-1:0]   k,
                                                         input logic [ID_W-1:0]     id,
                                                         input logic [AMOUNT_W-1:0] amt);
    contact_result_t res;
    res = '0;
    case (k)
      KIND_HEARD: begin
        // id zero and ids past the table are dropped
        if (id == 0 || id >= NUM_ENTRIES) begin
          res.status = 1'b1;
        end else begin
          shadow_current[id] = shadow_current[id] + count_t'(amt);
        end
      end
      KIND_SNAPSHOT: begin
        foreach (shadow_sent[i]) shadow_sent[i] = shadow_current[i];
      end
      KIND_ACK: begin
        // subtraction wraps at the counter width
        foreach (shadow_current[i]) begin
          shadow_current[i] = shadow_current[i] - shadow_sent[i];
          shadow_sent[i]    = '0;
        end
      end
      KIND_READ: begin
        if (id >= NUM_ENTRIES) begin
          res.status = 1'b1;
        end else begin
          res.count_high = shadow_sent[id][COUNT_W-1:HIGH_LSB];
        end
      end
    endcase
    return res;
  endfunction

  // results are matched before the item of the same edge is queued
  always @(posedge clk) begin : track_items
    contact_result_t want;
    if (rst) begin
      foreach (shadow_current[i]) begin
        shadow_current[i] = '0;
        shadow_sent[i]    = '0;
      end
      awaited_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with no item outstanding: count_high %h, status %b",
                 count_high, status);
          error_total++;
        end else begin
          want = awaited_results.pop_front();
          if (count_high !== want.count_high) begin
            $error("count_high mismatch: expected %h, got %h", want.count_high, count_high);
            error_total++;
          end
          if (status !== want.status) begin
            $error("status mismatch: expected %b, got %b", want.status, status);
            error_total++;
          end
        end
      end
      if (item_valid && item_ready) begin
        awaited_results.push_back(apply_contact_item(kind, entry_id, amount));
      end
    end
    mismatch_count <= error_total;
    awaited_count  <= awaited_results.size();
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: item stimulus, result sink and verdict for contact_count_table_core
// depends on cct_pkg, contact_count_table_core and contact_count_checker
module tb_top;
  import cct_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 2 * NUM_ENTRIES + 16;
  localparam int MIX_ROUNDS   = 8;
  localparam int WRAP_HEARDS  = 280;
  localparam int WRAP_SNAP_AT = 40;
  localparam int IDLE_CAPS [3] = '{0, 4, 14};

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic [KIND_W-1:0]   kind         = KIND_HEARD;
  logic [ID_W-1:0]     entry_id     = '0;
  logic [AMOUNT_W-1:0] amount       = '0;
  logic                result_ready = 1'b0;
  logic                item_ready;
  logic                result_valid;
  logic [HIGH_W-1:0]   count_high;
  logic                status;

  int mismatch_count;
  int awaited_count;
  int gap_limit   = 0;
  int cycle_count = 0;
  int kind_tally [4] = '{0, 0, 0, 0};

  contact_count_table_core uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .kind         (kind),
    .entry_id     (entry_id),
    .amount       (amount),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .count_high   (count_high),
    .status       (status)
  );

  contact_count_checker u_count_check (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .kind           (kind),
    .entry_id       (entry_id),
    .amount         (amount),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .count_high     (count_high),
    .status         (status),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // watchdog on the whole run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // result sink: random stall before each result, valid stays held meanwhile
  initial begin : result_sink
    int stall;
    forever begin
      stall = $urandom_range(0, gap_limit);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!(result_valid && result_ready)) @(posedge clk);
    end
  end

  // present one item after a random gap and hold it until accepted
  task automatic send_item(input logic [KIND_W-1:0]   k,
                           input logic [ID_W-1:0]     id,
                           input logic [AMOUNT_W-1:0] amt);
    int gap;
    gap = $urandom_range(0, gap_limit);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind       <= k;
    entry_id   <= id;
    amount     <= amt;
    @(posedge clk);
    while (!(item_valid && item_ready)) @(posedge clk);
    kind_tally[k]++;
  endtask

  // mostly ids inside the table, some across the whole field
  function automatic logic [ID_W-1:0] draw_id();
    if ($urandom_range(0, 3) != 0) return ID_W'($urandom_range(0, NUM_ENTRIES - 1));
    return ID_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [AMOUNT_W-1:0] draw_amount();
    return AMOUNT_W'($urandom_range(0, 65535));
  endfunction

  initial begin : stimulus
    int hot_id;
    int round;
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty tables, ignored ids, field extremes, report cycle
    send_item(KIND_READ, 8'd0, 16'h0000);
    send_item(KIND_READ, 8'(NUM_ENTRIES - 1), 16'hFFFF);
    send_item(KIND_READ, 8'(NUM_ENTRIES), 16'h0000);
    send_item(KIND_READ, 8'hFF, 16'hFFFF);
    send_item(KIND_HEARD, 8'd0, 16'hFFFF);
    send_item(KIND_HEARD, 8'(NUM_ENTRIES), 16'h1234);
    send_item(KIND_HEARD, 8'hFF, 16'hFFFF);
    send_item(KIND_HEARD, 8'd1, 16'hFFFF);
    send_item(KIND_HEARD, 8'(NUM_ENTRIES - 1), 16'hFFFF);
    send_item(KIND_HEARD, 8'(NUM_ENTRIES - 1), 16'h0101);
    send_item(KIND_HEARD, 8'd1, 16'h0000);
    send_item(KIND_ACK, 8'hFF, 16'hFFFF);
    send_item(KIND_READ, 8'd1, 16'h0000);
    send_item(KIND_SNAPSHOT, 8'hAA, 16'h5555);
    send_item(KIND_READ, 8'd1, 16'h0000);
    send_item(KIND_READ, 8'(NUM_ENTRIES - 1), 16'h0000);
    send_item(KIND_HEARD, 8'(NUM_ENTRIES - 1), 16'h8000);
    send_item(KIND_SNAPSHOT, 8'h55, 16'hAAAA);
    send_item(KIND_SNAPSHOT, 8'h00, 16'h0000);
    send_item(KIND_READ, 8'(NUM_ENTRIES - 1), 16'h0000);
    send_item(KIND_ACK, 8'h00, 16'h0000);
    send_item(KIND_READ, 8'(NUM_ENTRIES - 1), 16'h0000);
    send_item(KIND_HEARD, 8'd2, 16'h00FF);
    send_item(KIND_READ, 8'd0, 16'h0000);

    // report cycles with random content and some noise items
    for (round = 0; round < MIX_ROUNDS; round++) begin
      gap_limit = IDLE_CAPS[round % 3];
      n = $urandom_range(4, 14);
      repeat (n) send_item(KIND_HEARD, draw_id(), draw_amount());
      send_item(KIND_SNAPSHOT, draw_id(), draw_amount());
      n = $urandom_range(2, 8);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) send_item(KIND_HEARD, draw_id(), draw_amount());
        else send_item(KIND_READ, draw_id(), draw_amount());
      end
      if ($urandom_range(0, 4) != 0) send_item(KIND_ACK, draw_id(), draw_amount());
      n = $urandom_range(0, 3);
      repeat (n) send_item(KIND_W'($urandom_range(0, 3)), draw_id(), draw_amount());
    end

    // one entry pushed through counter wrap, snapshot taken before the wrap
    hot_id = $urandom_range(1, NUM_ENTRIES - 1);
    for (n = 0; n < WRAP_HEARDS; n++) begin
      gap_limit = IDLE_CAPS[(n / 70) % 3];
      if (n == WRAP_SNAP_AT) begin
        send_item(KIND_SNAPSHOT, draw_id(), draw_amount());
        send_item(KIND_READ, ID_W'(hot_id), draw_amount());
      end
      if (n % 25 == 0) send_item(KIND_READ, ID_W'(hot_id), draw_amount());
      send_item(KIND_HEARD, ID_W'(hot_id), AMOUNT_W'($urandom_range(16'hFF00, 16'hFFFF)));
    end
    send_item(KIND_READ, ID_W'(hot_id), draw_amount());
    send_item(KIND_ACK, draw_id(), draw_amount());
    send_item(KIND_READ, ID_W'(hot_id), draw_amount());
    send_item(KIND_SNAPSHOT, draw_id(), draw_amount());
    send_item(KIND_READ, ID_W'(hot_id), draw_amount());
    item_valid <= 1'b0;

    // drain outstanding results, then allow for a late stray one
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items: %0d heard, %0d snapshot, %0d acknowledge, %0d read",
             kind_tally[KIND_HEARD] + kind_tally[KIND_SNAPSHOT] + kind_tally[KIND_ACK]
             + kind_tally[KIND_READ], kind_tally[KIND_HEARD], kind_tally[KIND_SNAPSHOT],
             kind_tally[KIND_ACK], kind_tally[KIND_READ]);
    $display("covered ignored ids, report cycles and entry %0d wrapping through add and subtract",
             hot_id);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/cct_pkg.sv
rtl/core/cct_alu.sv
rtl/core/contact_count_table_core.sv
rtl/core/cct_checker.sv
bench/contact_count_checker.sv
bench/tb_top.sv
